// ----- design/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, keyword tables and byte helpers for the path reference scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  localparam int KW_COUNT = 5;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } path_word_t;

  typedef struct packed {
    logic       two;
    path_word_t w0;
    path_word_t w1;
  } path_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [8*6-1:0]  KW_EXECVM = "execvm";
  localparam logic [8*25-1:0] KW_PPFLN  = "preprocessfilelinenumbers";
  localparam logic [8*14-1:0] KW_PPF    = "preprocessfile";
  localparam logic [8*8-1:0]  KW_LOAD   = "loadfile";
  localparam logic [8*4-1:0]  KW_EXEC   = "exec";

  function automatic logic [4:0] kw_len(input logic [2:0] k);
    logic [4:0] len;
    case (k)
      3'd0:    len = 5'd6;
      3'd1:    len = 5'd25;
      3'd2:    len = 5'd14;
      3'd3:    len = 5'd8;
      3'd4:    len = 5'd4;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [4:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      3'd0: begin
        if (pos < 5'd6) c = KW_EXECVM[8*(5 - int'(pos)) +: 8];
      end
      3'd1: begin
        if (pos < 5'd25) c = KW_PPFLN[8*(24 - int'(pos)) +: 8];
      end
      3'd2: begin
        if (pos < 5'd14) c = KW_PPF[8*(13 - int'(pos)) +: 8];
      end
      3'd3: begin
        if (pos < 5'd8) c = KW_LOAD[8*(7 - int'(pos)) +: 8];
      end
      3'd4: begin
        if (pos < 5'd4) c = KW_EXEC[8*(3 - int'(pos)) +: 8];
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ident(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || (b == "_");
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= "A" && b <= "Z") r = b + 8'd32;
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09);
  endfunction

  localparam logic [7:0] QUOTE_CHAR = 8'h22;

endpackage

`default_nettype wire

// ----- design/spr_front.sv -----
// ----------------------------------------------------------------------------
// spr_front
// Accepts text bytes, tracks words against the keywords and produces the
// path words caused by each byte as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_front
  import spr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          text_valid,
  output logic               text_stall,
  input  wire logic [7:0]    text_byte,
  input  wire logic          text_last,
  input  wire queue_status_t q_status,
  output logic               push,
  output path_entry_t        push_entry
);

  typedef enum logic [1:0] {
    MODE_SCAN  = 2'd0,
    MODE_SKIP  = 2'd1,
    MODE_QUOTE = 2'd2
  } mode_t;

  mode_t       mode, mode_next;
  logic [4:0]  alive, alive_next;
  logic [4:0]  word_pos, word_pos_next;
  logic        prev_ident, prev_ident_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;

  logic        accept;
  logic [1:0]  n_words;
  path_word_t  w0, w1;

  assign text_stall = q_status.full;
  assign accept     = text_valid && !text_stall;

  always_comb begin
    logic       do_scan;
    logic       prev_eff;
    logic [4:0] base_alive;
    logic [4:0] base_pos;
    logic [7:0] lb;
    logic       hit;
    do_scan         = 1'b0;
    prev_eff        = prev_ident;
    base_alive      = alive;
    base_pos        = word_pos;
    lb              = fold_case(text_byte);
    hit             = 1'b0;
    mode_next       = mode;
    alive_next      = alive;
    word_pos_next   = word_pos;
    prev_ident_next = prev_ident;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    n_words         = 2'd0;
    w0              = '0;
    w1              = '0;

    case (mode)
      MODE_SKIP: begin
        if (is_blank(text_byte)) begin
          mode_next = MODE_SKIP;
        end else if (text_byte == QUOTE_CHAR) begin
          mode_next       = MODE_QUOTE;
          held_valid_next = 1'b0;
        end else begin
          mode_next = MODE_SCAN;
          prev_eff  = 1'b0;
          do_scan   = 1'b1;
        end
      end
      MODE_QUOTE: begin
        if (text_byte == QUOTE_CHAR) begin
          if (held_valid) begin
            w0      = '{data: held_byte, last: 1'b1};
            n_words = 2'd1;
          end
          held_valid_next = 1'b0;
          held_byte_next  = 8'h00;
          mode_next       = MODE_SCAN;
          prev_ident_next = 1'b0;
        end else begin
          if (held_valid) begin
            w0      = '{data: held_byte, last: 1'b0};
            n_words = 2'd1;
          end
          held_byte_next  = text_byte;
          held_valid_next = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_SCAN;
        do_scan   = 1'b1;
      end
    endcase

    if (do_scan) begin
      if (is_ident(text_byte)) begin
        base_alive = prev_eff ? alive : 5'h1F;
        base_pos   = prev_eff ? word_pos : 5'd0;
        for (int k = 0; k < KW_COUNT; k++) begin
          alive_next[k] = base_alive[k] && (base_pos < kw_len(3'(k))) &&
                          (kw_char(3'(k), base_pos) == lb);
        end
        word_pos_next   = (base_pos < 5'd31) ? base_pos + 5'd1 : 5'd31;
        prev_ident_next = 1'b1;
      end else begin
        if (prev_eff) begin
          for (int k = 0; k < KW_COUNT; k++) begin
            if (alive[k] && word_pos == kw_len(3'(k))) hit = 1'b1;
          end
        end
        prev_ident_next = 1'b0;
        if (hit) begin
          if (is_blank(text_byte)) begin
            mode_next = MODE_SKIP;
          end else if (text_byte == QUOTE_CHAR) begin
            mode_next       = MODE_QUOTE;
            held_valid_next = 1'b0;
          end
        end
      end
    end

    if (text_last) begin
      if (mode_next == MODE_QUOTE && held_valid_next) begin
        if (n_words == 2'd0) begin
          w0 = '{data: held_byte_next, last: 1'b1};
        end else begin
          w1 = '{data: held_byte_next, last: 1'b1};
        end
        n_words = n_words + 2'd1;
      end
      mode_next       = MODE_SCAN;
      alive_next      = 5'h1F;
      word_pos_next   = 5'd0;
      prev_ident_next = 1'b0;
      held_byte_next  = 8'h00;
      held_valid_next = 1'b0;
    end
  end

  assign push       = accept && (n_words != 2'd0);
  assign push_entry = '{two: (n_words == 2'd2), w0: w0, w1: w1};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SCAN;
      alive      <= 5'h1F;
      word_pos   <= 5'd0;
      prev_ident <= 1'b0;
      held_byte  <= 8'h00;
      held_valid <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      alive      <= alive_next;
      word_pos   <= word_pos_next;
      prev_ident <= prev_ident_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
    end
  end

  // A held path byte only exists while inside a quoted path.
  a_held_in_quote: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> mode == MODE_QUOTE)
    else $error("held path byte outside a quoted path");

  // The final byte of a text returns the scanner to its idle state.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    accept && text_last |=> mode == MODE_SCAN && !held_valid && !prev_ident)
    else $error("scanner state not cleared after end of text");

endmodule

`default_nettype wire

// ----- design/spr_queue.sv -----
// ----------------------------------------------------------------------------
// spr_queue
// Short first-in first-out queue of path entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_queue
  import spr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire path_entry_t  push_entry,
  input  wire logic         pop,
  output path_entry_t       head,
  output queue_status_t     status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  path_entry_t       mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- design/spr_back.sv -----
// ----------------------------------------------------------------------------
// spr_back
// Takes queue entries and delivers their one or two path words through a
// registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_back
  import spr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire path_entry_t   head,
  input  wire queue_status_t q_status,
  output logic               pop,
  output logic               path_valid,
  input  wire logic          path_stall,
  output logic [7:0]         path_byte,
  output logic               path_end
);

  logic       load;
  logic       pend;
  path_word_t second;

  assign load = !path_valid || !path_stall;
  assign pop  = load && !pend && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_valid <= 1'b0;
      pend       <= 1'b0;
    end else if (load) begin
      if (pend) begin
        path_valid <= 1'b1;
        pend       <= 1'b0;
      end else if (!q_status.empty) begin
        path_valid <= 1'b1;
        pend       <= head.two;
      end else begin
        path_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        path_byte <= second.data;
        path_end  <= second.last;
      end else if (!q_status.empty) begin
        path_byte <= head.w0.data;
        path_end  <= head.w0.last;
        second    <= head.w1;
      end
    end
  end

  // A pending second word always sits behind a word already on the output.
  a_pend_behind_valid: assert property (@(posedge clk) disable iff (rst)
    pend |-> path_valid)
    else $error("second word pending without a word on the output");

endmodule

`default_nettype wire

// ----- design/script_path_reference_scanner_core.sv -----
// ----------------------------------------------------------------------------
// script_path_reference_scanner_core
// Extracts the double-quoted path arguments of the script keywords execVM,
// preprocessFileLineNumbers, preprocessFile, loadFile and exec.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and never stalls the text side
// while its entry queue has room. Each byte is classified by the front scanner
// in the cycle it is accepted; the path words it causes (none, one or two) go
// into a queue of QUEUE_DEPTH entries. The back end delivers one path word per
// cycle while path_stall is low, from a registered output stage, so a byte
// that ends an unterminated path and yields two words occupies the output for
// both words in turn. A result word passes through the queue memory and the
// output register before it is on the output. The last byte of a path is held
// back until the closing quote or the end of the text.
// ----------------------------------------------------------------------------
`default_nettype none

module script_path_reference_scanner_core
  import spr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       text_last,
  output logic            path_valid,
  input  wire logic       path_stall,
  output logic [7:0]      path_byte,
  output logic            path_end
);

  queue_status_t q_status;
  logic          push;
  logic          pop;
  path_entry_t   push_entry;
  path_entry_t   head;

  spr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .text_last  (text_last),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  spr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  spr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .path_valid (path_valid),
    .path_stall (path_stall),
    .path_byte  (path_byte),
    .path_end   (path_end)
  );

endmodule

`default_nettype wire
